// ===== rtl/two_channel_lux_calc_macros.svh =====
// ----------------------------------------------------------------------------
// two_channel_lux_calc_macros
// Assertion macros shared by the lux calculator modules.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_LUX_CALC_MACROS_SVH
`define TWO_CHANNEL_LUX_CALC_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define TCLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define TCLC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCLC_ASSERT(label, clk, rst_n, prop, msg)
`define TCLC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define TCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/tclc_pkg.sv =====
// ----------------------------------------------------------------------------
// tclc_pkg
// Widths, band codes, coefficients and table functions of the lux calculator.
// ----------------------------------------------------------------------------
package tclc_pkg;

    localparam int RATIO_FRAC_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int COUNT_W  = 16;
    localparam int LUX_W    = 22;
    localparam int BAND_W   = 3;
    localparam int POW_W    = 16;
    localparam int REM_W    = COUNT_W + 1;
    localparam int COEF_W   = 9;
    localparam int PROD_W   = COEF_W + COUNT_W;
    localparam int SLOPE_W  = 10;
    localparam int SLOPE_PROD_W = SLOPE_W + POW_W;
    localparam int WIDE_W   = PROD_W + COUNT_W;
    localparam int RECIP_W  = 32;
    localparam int QPROD_W  = PROD_W + RECIP_W;

    localparam int QUEUE_WIDTH_DEF = 2 * COUNT_W + BAND_W + RATIO_FRAC_BITS_DEF;

    localparam int unsigned LUX_MAX = 2064352;

    // low band: ch0 * (315 * 2^16 - 593 * p) / (10 * 2^16)
    localparam logic [PROD_W-1:0]  LOW_BASE  = PROD_W'(315 * 65536);
    localparam logic [SLOPE_W-1:0] LOW_SLOPE = SLOPE_W'(593);
    localparam int                 LOW_DROP  = POW_W;

    localparam logic [COEF_W-1:0] MID1_A = COEF_W'(224);
    localparam logic [COEF_W-1:0] MID1_B = COEF_W'(310);
    localparam logic [COEF_W-1:0] MID2_A = COEF_W'(128);
    localparam logic [COEF_W-1:0] MID2_B = COEF_W'(153);
    localparam logic [COEF_W-1:0] HIGH_A = COEF_W'(146);
    localparam logic [COEF_W-1:0] HIGH_B = COEF_W'(112);

    // exact floor division for operands below 2^32
    localparam logic [RECIP_W-1:0] RECIP_TEN     = 32'hCCCC_CCCD;
    localparam int                 SHIFT_TEN     = 35;
    localparam logic [RECIP_W-1:0] RECIP_HUNDRED = 32'h51EB_851F;
    localparam int                 SHIFT_HUNDRED = 37;

    // band edges in hundredths
    localparam int unsigned PCT_T1 = 61;
    localparam int unsigned PCT_T2 = 80;
    localparam int unsigned PCT_T3 = 130;

    typedef enum logic [BAND_W-1:0] {
        BAND_LOW  = 3'd0,
        BAND_MID1 = 3'd1,
        BAND_MID2 = 3'd2,
        BAND_HIGH = 3'd3,
        BAND_OVER = 3'd4,
        BAND_DARK = 3'd5
    } band_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // threshold pct/100 in ratio units, rounded to nearest
    function automatic int unsigned ratio_threshold(int unsigned pct, int unsigned frac_bits);
        return (pct * (32'd1 << frac_bits) + 32'd50) / 32'd100;
    endfunction

    // floor(2^16 * (r / 2^frac)^1.4): largest p with 2^32 * p^5 <= s^7
    function automatic logic [POW_W-1:0] pow14_entry(int unsigned r, int unsigned frac_bits);
        logic [127:0]     s;
        logic [127:0]     rhs;
        logic [127:0]     lhs;
        logic [POW_W-1:0] p;
        logic [POW_W-1:0] c;
        int               i;
        int               b;
        s   = 128'((r << (POW_W - frac_bits)) & 32'h1FFFF);
        rhs = 128'd1;
        for (i = 0; i < 7; i++)
            rhs = rhs * s;
        p = '0;
        for (b = POW_W - 1; b >= 0; b--)
        begin
            c   = p | (POW_W'(1) << b);
            lhs = 128'd1 << 32;
            for (i = 0; i < 5; i++)
                lhs = lhs * 128'(c);
            if (lhs <= rhs)
                p = c;
        end
        return p;
    endfunction

endpackage

// ===== rtl/tclc_front.sv =====
// ----------------------------------------------------------------------------
// tclc_front
// Accepts count pairs, forms the ratio in a one-bit-per-stage divider and
// classifies each transaction into its band.
// ----------------------------------------------------------------------------
`include "two_channel_lux_calc_macros.svh"

module tclc_front #(
    parameter int RATIO_FRAC_BITS = tclc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tclc_pkg::COUNT_W-1:0]   broadband_count,
    input  logic [tclc_pkg::COUNT_W-1:0]   infrared_count,
    input  logic                           queue_full,
    output logic                           busy,
    output logic                           out_valid,
    output logic [tclc_pkg::COUNT_W-1:0]   out_ch0,
    output logic [tclc_pkg::COUNT_W-1:0]   out_ch1,
    output tclc_pkg::band_t                out_band,
    output logic [RATIO_FRAC_BITS-1:0]     out_idx
);
    import tclc_pkg::*;

    localparam int NSTG = RATIO_FRAC_BITS + 1;
    localparam int QW   = RATIO_FRAC_BITS + 1;

    localparam logic [QW-1:0] T0 = QW'(32'd1 << (RATIO_FRAC_BITS - 1));
    localparam logic [QW-1:0] T1 = QW'(ratio_threshold(PCT_T1, RATIO_FRAC_BITS));
    localparam logic [QW-1:0] T2 = QW'(ratio_threshold(PCT_T2, RATIO_FRAC_BITS));
    localparam logic [QW-1:0] T3 = QW'(ratio_threshold(PCT_T3, RATIO_FRAC_BITS));

    logic               stall;
    logic               accept;

    // index 0 is the input register, index k holds k quotient bits
    logic               valid_reg [NSTG+1];
    logic               valid_next [NSTG+1];
    logic               dark_reg [NSTG+1];
    logic               dark_next [NSTG+1];
    logic               over_reg [NSTG+1];
    logic               over_next [NSTG+1];
    logic [COUNT_W-1:0] ch0_reg [NSTG+1];
    logic [COUNT_W-1:0] ch0_next [NSTG+1];
    logic [COUNT_W-1:0] ch1_reg [NSTG+1];
    logic [COUNT_W-1:0] ch1_next [NSTG+1];
    logic [REM_W-1:0]   rem_reg [NSTG+1];
    logic [REM_W-1:0]   rem_next [NSTG+1];
    logic [QW-1:0]      quo_reg [NSTG+1];
    logic [QW-1:0]      quo_next [NSTG+1];

    logic [QW-1:0]      ratio;
    band_t              band_sel;

    assign stall  = valid_reg[NSTG] && queue_full;
    assign busy   = stall;
    assign accept = start && !stall;

    assign valid_next[0] = accept;
    assign dark_next[0]  = (broadband_count == '0);
    // ratio of two or more is past every band edge
    assign over_next[0]  = {1'b0, infrared_count} >= {broadband_count, 1'b0};
    assign ch0_next[0]   = broadband_count;
    assign ch1_next[0]   = infrared_count;
    assign rem_next[0]   = {1'b0, infrared_count};
    assign quo_next[0]   = '0;

    for (genvar k = 1; k <= NSTG; k++)
    begin : g_div
        logic [REM_W-1:0] trial;
        logic             ge;

        if (k == 1)
        begin : g_int
            assign trial = rem_reg[k-1];
        end
        else
        begin : g_frac
            assign trial = {rem_reg[k-1][COUNT_W-1:0], 1'b0};
        end

        assign ge           = trial >= {1'b0, ch0_reg[k-1]};
        assign valid_next[k] = valid_reg[k-1];
        assign dark_next[k]  = dark_reg[k-1];
        assign over_next[k]  = over_reg[k-1];
        assign ch0_next[k]   = ch0_reg[k-1];
        assign ch1_next[k]   = ch1_reg[k-1];
        assign rem_next[k]   = ge ? (trial - {1'b0, ch0_reg[k-1]}) : trial;
        assign quo_next[k]   = quo_reg[k-1] | (QW'(ge) << (NSTG - k));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (!stall)
        begin
            for (int k = 0; k <= NSTG; k++)
                valid_reg[k] <= valid_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                dark_reg[k] <= dark_next[k];
                over_reg[k] <= over_next[k];
                ch0_reg[k]  <= ch0_next[k];
                ch1_reg[k]  <= ch1_next[k];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign ratio = quo_reg[NSTG];

    always_comb
    begin
        if (dark_reg[NSTG])
            band_sel = BAND_DARK;
        else if (over_reg[NSTG])
            band_sel = BAND_OVER;
        else if (ratio <= T0)
            band_sel = BAND_LOW;
        else if (ratio <= T1)
            band_sel = BAND_MID1;
        else if (ratio <= T2)
            band_sel = BAND_MID2;
        else if (ratio <= T3)
            band_sel = BAND_HIGH;
        else
            band_sel = BAND_OVER;
    end

    assign out_valid = valid_reg[NSTG];
    assign out_ch0   = ch0_reg[NSTG];
    assign out_ch1   = ch1_reg[NSTG];
    assign out_band  = band_sel;
    // table index only matters in the low band, keep it inside the table
    assign out_idx   = (band_sel == BAND_LOW) ? ratio[RATIO_FRAC_BITS-1:0] : '0;

    `TCLC_ASSERT_IMPLIES(a_stall_valid, clk, rst_n, stall, valid_reg[NSTG], "stall without a pending transaction")
    `TCLC_ASSERT_IMPLIES(a_rem_bound, clk, rst_n, valid_reg[NSTG] && !dark_reg[NSTG] && !over_reg[NSTG], rem_reg[NSTG] < {1'b0, ch0_reg[NSTG]}, "divider remainder out of range")
    `TCLC_ASSERT_NEXT(a_stall_hold, clk, rst_n, stall, $stable(quo_reg[NSTG]) && valid_reg[NSTG], "classified transaction lost during stall")

endmodule

// ===== rtl/tclc_queue.sv =====
// ----------------------------------------------------------------------------
// tclc_queue
// Short first-in first-out queue between classifier and arithmetic.
// ----------------------------------------------------------------------------
`include "two_channel_lux_calc_macros.svh"

module tclc_queue #(
    parameter int WIDTH = tclc_pkg::QUEUE_WIDTH_DEF,
    parameter int DEPTH = tclc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output tclc_pkg::queue_stat_t stat
);
    import tclc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    `TCLC_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push && !pop, !stat.full, "push into full queue")
    `TCLC_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !stat.empty, "pop from empty queue")
    `TCLC_ASSERT(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== rtl/tclc_back.sv =====
// ----------------------------------------------------------------------------
// tclc_back
// Band arithmetic: power table read, coefficient products, constant
// division by reciprocal multiply and the result register.
// ----------------------------------------------------------------------------
`include "two_channel_lux_calc_macros.svh"

module tclc_back #(
    parameter int RATIO_FRAC_BITS = tclc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [tclc_pkg::COUNT_W-1:0] in_ch0,
    input  logic [tclc_pkg::COUNT_W-1:0] in_ch1,
    input  tclc_pkg::band_t              in_band,
    input  logic [RATIO_FRAC_BITS-1:0]   in_idx,
    output logic                         done,
    output logic [tclc_pkg::LUX_W-1:0]   lux_milli,
    output logic [tclc_pkg::BAND_W-1:0]  band
);
    import tclc_pkg::*;

    localparam int ROM_DEPTH = (1 << (RATIO_FRAC_BITS - 1)) + 1;

    logic [POW_W-1:0] rom_data [ROM_DEPTH];

    for (genvar i = 0; i < ROM_DEPTH; i++)
    begin : g_rom
        assign rom_data[i] = pow14_entry(i, RATIO_FRAC_BITS);
    end

    // stage 1: table read and linear products
    logic [COEF_W-1:0]       coef_a;
    logic [COEF_W-1:0]       coef_b;
    logic [PROD_W-1:0]       pos_next;
    logic [PROD_W-1:0]       neg_next;
    logic                    b1_valid_reg;
    band_t                   b1_band_reg;
    logic [COUNT_W-1:0]      b1_ch0_reg;
    logic [POW_W-1:0]        b1_pow_reg;
    logic [PROD_W-1:0]       b1_pos_reg;
    logic [PROD_W-1:0]       b1_neg_reg;

    // stage 2: low band coefficient and clamped linear difference
    logic [SLOPE_PROD_W-1:0] slope_prod;
    logic [PROD_W-1:0]       coef0_next;
    logic [PROD_W-1:0]       diff_next;
    logic                    b2_valid_reg;
    band_t                   b2_band_reg;
    logic [COUNT_W-1:0]      b2_ch0_reg;
    logic [PROD_W-1:0]       b2_coef0_reg;
    logic [PROD_W-1:0]       b2_diff_reg;

    // stage 3: low band product
    logic [WIDE_W-1:0]       wide_next;
    logic                    b3_valid_reg;
    band_t                   b3_band_reg;
    logic [WIDE_W-1:0]       b3_wide_reg;
    logic [PROD_W-1:0]       b3_diff_reg;

    // stage 4: reciprocal multiply
    logic [PROD_W-1:0]       num;
    logic [RECIP_W-1:0]      recip;
    logic [QPROD_W-1:0]      qprod_next;
    logic                    b4_valid_reg;
    band_t                   b4_band_reg;
    logic [QPROD_W-1:0]      b4_qprod_reg;

    // stage 5: result register
    logic [QPROD_W-1:0]      quot;
    logic [LUX_W-1:0]        lux_next;
    logic                    done_reg;
    band_t                   band_reg;
    logic [LUX_W-1:0]        lux_milli_reg;

    always_comb
    begin
        unique case (in_band)
            BAND_MID1:
            begin
                coef_a = MID1_A;
                coef_b = MID1_B;
            end
            BAND_MID2:
            begin
                coef_a = MID2_A;
                coef_b = MID2_B;
            end
            BAND_HIGH:
            begin
                coef_a = HIGH_A;
                coef_b = HIGH_B;
            end
            default:
            begin
                coef_a = '0;
                coef_b = '0;
            end
        endcase
        pos_next = coef_a * in_ch0;
        neg_next = coef_b * in_ch1;
    end

    always_comb
    begin
        slope_prod = LOW_SLOPE * b1_pow_reg;
        coef0_next = ({1'b0, LOW_BASE} > slope_prod)
                   ? PROD_W'({1'b0, LOW_BASE} - slope_prod) : '0;
        diff_next  = (b1_pos_reg > b1_neg_reg) ? (b1_pos_reg - b1_neg_reg) : '0;
    end

    assign wide_next = b2_ch0_reg * b2_coef0_reg;

    always_comb
    begin
        unique case (b3_band_reg) inside
            BAND_LOW:                       num = b3_wide_reg[WIDE_W-1:LOW_DROP];
            BAND_MID1, BAND_MID2, BAND_HIGH: num = b3_diff_reg;
            default:                        num = '0;
        endcase
        recip      = (b3_band_reg == BAND_HIGH) ? RECIP_HUNDRED : RECIP_TEN;
        qprod_next = num * recip;
    end

    always_comb
    begin
        quot     = (b4_band_reg == BAND_HIGH) ? (b4_qprod_reg >> SHIFT_HUNDRED)
                                              : (b4_qprod_reg >> SHIFT_TEN);
        lux_next = quot[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            done_reg     <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_band_reg   <= in_band;
        b1_ch0_reg    <= in_ch0;
        b1_pow_reg    <= rom_data[in_idx];
        b1_pos_reg    <= pos_next;
        b1_neg_reg    <= neg_next;

        b2_band_reg   <= b1_band_reg;
        b2_ch0_reg    <= b1_ch0_reg;
        b2_coef0_reg  <= coef0_next;
        b2_diff_reg   <= diff_next;

        b3_band_reg   <= b2_band_reg;
        b3_wide_reg   <= wide_next;
        b3_diff_reg   <= b2_diff_reg;

        b4_band_reg   <= b3_band_reg;
        b4_qprod_reg  <= qprod_next;

        band_reg      <= b4_band_reg;
        lux_milli_reg <= lux_next;
    end

    assign done      = done_reg;
    assign lux_milli = lux_milli_reg;
    assign band      = band_reg;

    `TCLC_ASSERT_IMPLIES(a_zero_bands, clk, rst_n, done_reg && (band_reg == BAND_OVER || band_reg == BAND_DARK), lux_milli_reg == '0, "nonzero lux in over or dark band")
    `TCLC_ASSERT_IMPLIES(a_lux_range, clk, rst_n, done_reg, lux_milli_reg <= LUX_W'(LUX_MAX), "lux above full scale")
    `TCLC_ASSERT(a_pipe_latency, clk, rst_n, done_reg == $past(b1_valid_reg, 4), "arithmetic pipeline lost or made a transaction")

endmodule

// ===== rtl/two_channel_lux_calc.sv =====
// ----------------------------------------------------------------------------
// two_channel_lux_calc
// Illuminance in millilux from a broadband and an infrared photodiode count.
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken on a rising edge with start high and busy low;
//   broadband_count and infrared_count are sampled on that edge
//   one result per transaction: done is high for one cycle with lux_milli
//   and band valid, in the order the transactions were taken
//   a result passes the input register, the one-bit-per-stage ratio divider,
//   the queue and five arithmetic stages
//   throughput is one transaction per cycle while busy is low; start may stay high
//   a short queue separates classification from arithmetic; busy rises only
//   if that queue fills, which the arithmetic side drains every cycle
//   the receiver cannot stall: done is a single-cycle strobe, take it then
//   reset empties every stage and the queue; no result is pending afterwards
//   band 5 marks a zero broadband count, band 4 a ratio above 1.30
// ----------------------------------------------------------------------------
module two_channel_lux_calc #(
    parameter int RATIO_FRAC_BITS = tclc_pkg::RATIO_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = tclc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tclc_pkg::COUNT_W-1:0] broadband_count,
    input  logic [tclc_pkg::COUNT_W-1:0] infrared_count,
    output logic                         busy,
    output logic                         done,
    output logic [tclc_pkg::LUX_W-1:0]   lux_milli,
    output logic [tclc_pkg::BAND_W-1:0]  band
);
    import tclc_pkg::*;

    localparam int ENTRY_W = 2 * COUNT_W + BAND_W + RATIO_FRAC_BITS;

    logic                       fr_valid;
    logic [COUNT_W-1:0]         fr_ch0;
    logic [COUNT_W-1:0]         fr_ch1;
    band_t                      fr_band;
    logic [RATIO_FRAC_BITS-1:0] fr_idx;

    logic                       q_push;
    logic                       q_pop;
    logic [ENTRY_W-1:0]         q_wdata;
    logic [ENTRY_W-1:0]         q_rdata;
    queue_stat_t                q_stat;

    logic [COUNT_W-1:0]         bk_ch0;
    logic [COUNT_W-1:0]         bk_ch1;
    band_t                      bk_band;
    logic [RATIO_FRAC_BITS-1:0] bk_idx;

    tclc_front #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .queue_full      (q_stat.full),
        .busy            (busy),
        .out_valid       (fr_valid),
        .out_ch0         (fr_ch0),
        .out_ch1         (fr_ch1),
        .out_band        (fr_band),
        .out_idx         (fr_idx)
    );

    assign q_push  = fr_valid && !q_stat.full;
    assign q_pop   = !q_stat.empty;
    assign q_wdata = {fr_ch0, fr_ch1, fr_band, fr_idx};

    tclc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    assign bk_ch0  = q_rdata[ENTRY_W-1 -: COUNT_W];
    assign bk_ch1  = q_rdata[ENTRY_W-COUNT_W-1 -: COUNT_W];
    assign bk_band = band_t'(q_rdata[RATIO_FRAC_BITS +: BAND_W]);
    assign bk_idx  = q_rdata[RATIO_FRAC_BITS-1:0];

    tclc_back #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_pop),
        .in_ch0    (bk_ch0),
        .in_ch1    (bk_ch1),
        .in_band   (bk_band),
        .in_idx    (bk_idx),
        .done      (done),
        .lux_milli (lux_milli),
        .band      (band)
    );

endmodule

// ===== test/two_channel_lux_calc_tb.sv =====
// ----------------------------------------------------------------------------
// two_channel_lux_calc_tb
// Self-checking bench for the lux calculator. Count pairs are sent back to back
// or with random gaps, and each pair's illuminance and band are worked out here
// from the counts. Every done strobe is compared with the oldest pending
// reading. Directed pairs cover zero broadband, count extremes and the band
// edges. A random part follows, aimed mostly at ratios inside the bands.
// ----------------------------------------------------------------------------
module two_channel_lux_calc_tb;

    import tclc_pkg::*;

    localparam int FRAC_BITS      = RATIO_FRAC_BITS_DEF;
    localparam int RANDOM_PAIRS   = 800;
    localparam int DRAIN_CYCLES   = FRAC_BITS + 7 + 20;
    localparam int CYCLE_LIMIT    = 250000;

    // band edges in ratio units
    localparam longint unsigned EDGE_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned EDGE_MID1 = (64'd61 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned EDGE_MID2 = (64'd80 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned EDGE_HIGH = (64'd130 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;

    typedef struct {
        logic [LUX_W-1:0] lux;
        band_t            band;
    } lux_reading_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [COUNT_W-1:0]  broadband_count;
    logic [COUNT_W-1:0]  infrared_count;
    logic                busy;
    logic                done;
    logic [LUX_W-1:0]    lux_milli;
    logic [BAND_W-1:0]   band;

    logic [POW_W-1:0]    pow_rom [0:EDGE_HALF];
    lux_reading_t        expected_readings [$];
    int                  mismatch_count;
    int                  readings_checked;
    int                  pairs_sent;
    int                  band_hits [0:5];
    int                  cycle_count;

    two_channel_lux_calc #(
        .RATIO_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .broadband_count(broadband_count),
        .infrared_count (infrared_count),
        .busy           (busy),
        .done           (done),
        .lux_milli      (lux_milli),
        .band           (band)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // 2^32 * p^5, compared against s^7 to pin down the exact table entry
    function automatic logic [127:0] scaled_fifth(longint unsigned p);
        logic [127:0] acc;
        acc = 128'd1 << 32;
        for (int i = 0; i < 5; i++)
            acc = acc * 128'(p);
        return acc;
    endfunction

    // floor(2^16 * (r / 2^F)^1.4): float estimate, then nudged to the exact floor
    function automatic logic [POW_W-1:0] ratio_pow_entry(int unsigned r);
        logic [127:0]    s;
        logic [127:0]    target;
        longint unsigned guess;
        s      = 128'(r) << (POW_W - FRAC_BITS);
        target = 128'd1;
        for (int i = 0; i < 7; i++)
            target = target * s;
        guess = longint'($floor(65536.0 * $pow(real'(r) / real'(1 << FRAC_BITS), 1.4)));
        while (guess < 65535 && scaled_fifth(guess + 1) <= target)
            guess++;
        while (guess > 0 && scaled_fifth(guess) > target)
            guess--;
        return POW_W'(guess);
    endfunction

    function automatic logic [63:0] linear_lux(logic [63:0] a, logic [63:0] c0,
                                               logic [63:0] b, logic [63:0] c1,
                                               logic [63:0] div);
        if (a * c0 <= b * c1)
            return 64'd0;
        return (a * c0 - b * c1) / div;
    endfunction

    function automatic lux_reading_t predict_reading(logic [COUNT_W-1:0] ch0,
                                                     logic [COUNT_W-1:0] ch1);
        lux_reading_t rd;
        logic [63:0]  c0;
        logic [63:0]  c1;
        logic [63:0]  ratio;
        logic [63:0]  base;
        logic [63:0]  drop;
        logic [63:0]  lux;
        c0  = 64'(ch0);
        c1  = 64'(ch1);
        lux = 64'd0;
        if (ch0 == '0)
        begin
            rd.band = BAND_DARK;
        end
        else
        begin
            ratio = (c1 << FRAC_BITS) / c0;
            if (ratio <= EDGE_HALF)
            begin
                rd.band = BAND_LOW;
                base    = 64'd315 * 64'd65536;
                drop    = 64'd593 * 64'(pow_rom[ratio]);
                lux     = (base > drop) ? c0 * (base - drop) / (64'd10 * 64'd65536) : 64'd0;
            end
            else if (ratio <= EDGE_MID1)
            begin
                rd.band = BAND_MID1;
                lux     = linear_lux(224, c0, 310, c1, 10);
            end
            else if (ratio <= EDGE_MID2)
            begin
                rd.band = BAND_MID2;
                lux     = linear_lux(128, c0, 153, c1, 10);
            end
            else if (ratio <= EDGE_HIGH)
            begin
                rd.band = BAND_HIGH;
                lux     = linear_lux(146, c0, 112, c1, 100);
            end
            else
            begin
                rd.band = BAND_OVER;
            end
        end
        rd.lux = lux[LUX_W-1:0];
        return rd;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_counts(input logic [COUNT_W-1:0] ch0, input logic [COUNT_W-1:0] ch1,
                               input int gap);
        @(negedge clk);
        start           <= 1'b1;
        broadband_count <= ch0;
        infrared_count  <= ch1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_readings.push_back(predict_reading(ch0, ch1));
        pairs_sent++;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic test_dark_input();
        send_counts(16'd0, 16'd0, pick_gap());
        send_counts(16'd0, 16'hFFFF, pick_gap());
        send_counts(16'd0, 16'(($urandom_range(1, 65534))), pick_gap());
    endtask

    task automatic test_count_extremes();
        send_counts(16'hFFFF, 16'd0, pick_gap());
        send_counts(16'hFFFF, 16'hFFFF, pick_gap());
        send_counts(16'd1, 16'hFFFF, pick_gap());
        send_counts(16'd1, 16'd0, pick_gap());
        send_counts(16'h5555, 16'hAAAA, pick_gap());
    endtask

    // ch0 = 2^F makes the ratio equal ch1, so each edge is hit exactly
    task automatic test_band_edges();
        logic [COUNT_W-1:0] unit;
        unit = COUNT_W'(1 << FRAC_BITS);
        send_counts(unit, COUNT_W'(EDGE_HALF), 0);
        send_counts(unit, COUNT_W'(EDGE_HALF + 1), 0);
        send_counts(unit, COUNT_W'(EDGE_MID1), 0);
        send_counts(unit, COUNT_W'(EDGE_MID1 + 1), 0);
        send_counts(unit, COUNT_W'(EDGE_MID2), 0);
        send_counts(unit, COUNT_W'(EDGE_MID2 + 1), 0);
        send_counts(unit, COUNT_W'(EDGE_HIGH), 0);
        send_counts(unit, COUNT_W'(EDGE_HIGH + 1), 0);
        // large counts near the edges, the last one closest to a negative high-band value
        send_counts(16'hFFFF, 16'd32800, pick_gap());
        send_counts(16'hFFFF, 16'd40000, pick_gap());
        send_counts(16'hFFFF, 16'd52400, pick_gap());
        send_counts(16'd50000, 16'd65039, pick_gap());
    endtask

    task automatic test_random_pairs();
        logic [COUNT_W-1:0] ch0;
        logic [COUNT_W-1:0] ch1;
        logic [63:0]        scaled;
        int                 kind;
        bit                 burst;
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            // alternate stretches of back-to-back pairs with gapped ones
            if (i % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 4)
            begin
                ch0 = '0;
                ch1 = COUNT_W'($urandom);
            end
            else if (kind < 20)
            begin
                ch0 = COUNT_W'($urandom);
                ch1 = COUNT_W'($urandom);
            end
            else if (kind < 30)
            begin
                ch0 = COUNT_W'($urandom_range(1, 40));
                ch1 = COUNT_W'($urandom_range(0, 60));
            end
            else
            begin
                // ratio aimed across the low, mid, high and over bands, with a little jitter
                ch0    = COUNT_W'($urandom_range(1, 65535));
                scaled = (64'(ch0) * 64'($urandom_range(0, 1500))) >> FRAC_BITS;
                scaled = scaled + 64'($urandom_range(0, 2));
                ch1    = (scaled > 64'hFFFF) ? 16'hFFFF : COUNT_W'(scaled);
            end
            send_counts(ch0, ch1, burst ? 0 : pick_gap());
        end
    endtask

    always @(posedge clk)
    begin
        lux_reading_t want;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: lux %0d band %0d",
                                          lux_milli, band));
            end
            else
            begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (band <= BAND_DARK)
                    band_hits[band]++;
                if (band !== want.band)
                    report_mismatch($sformatf("band %0d, expected %0d", band, want.band));
                if (lux_milli !== want.lux)
                    report_mismatch($sformatf("lux_milli %0d, expected %0d (band %0d)",
                                              lux_milli, want.lux, want.band));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pending", cycle_count,
                     expected_readings.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        broadband_count  = '0;
        infrared_count   = '0;
        mismatch_count   = 0;
        readings_checked = 0;
        pairs_sent       = 0;
        cycle_count      = 0;
        for (int b = 0; b < 6; b++)
            band_hits[b] = 0;
        for (int r = 0; r <= EDGE_HALF; r++)
            pow_rom[r] = ratio_pow_entry(r);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_dark_input();
        test_count_extremes();
        test_band_edges();
        test_random_pairs();

        @(negedge clk);
        start <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d count pairs sent, %0d readings checked, %0d mismatches",
                 pairs_sent, readings_checked, mismatch_count);
        $display("readings per band: low %0d mid1 %0d mid2 %0d high %0d over %0d dark %0d",
                 band_hits[0], band_hits[1], band_hits[2], band_hits[3], band_hits[4],
                 band_hits[5]);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
